// ===== hw/rtl/fbml_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbml_pkg
// Shared types and constants for the frequency band and mode lookup.
// ----------------------------------------------------------------------------
package fbml_pkg;

  localparam int MAX_BANDS_DEF   = 64;
  localparam int MAX_REGIONS_DEF = 16;

  localparam int FREQ_W   = 31;
  localparam int CNT_W    = 5;   // stored region count
  localparam int MODE_W   = 4;
  localparam int CFG_W    = 7;
  localparam int BSLOT_W  = 6;
  localparam int RSLOT_W  = 4;
  localparam int CMD_W    = 2;

  localparam logic [FREQ_W-1:0] NEAR_LIMIT = 31'd999999999;

  typedef enum logic [CMD_W-1:0] {
    CMD_BAND_WR   = 2'd0,
    CMD_REGION_WR = 2'd1,
    CMD_LOOKUP    = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BRD,
    ST_BEVAL,
    ST_BCMP,
    ST_RRD,
    ST_RCHK,
    ST_DONE
  } state_t;

endpackage : fbml_pkg
`default_nettype wire

// ===== hw/rtl/fbml_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fbml_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module fbml_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule : fbml_ram
`default_nettype wire

// ===== hw/rtl/frequency_band_and_mode_lookup.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Write requests (band or region entry) are stored when accepted, leave the block idle and give no result.
// A lookup walks the bands in order through the band RAM read port (read,
// evaluate and compare states per band), checks the regions of each containing
// band through the region RAM read port, and stops at the first matching region.
// One request at a time; a finished result waits in the output register.
// Reset clears control and bands_in_use; table contents are undefined until written.
// ----------------------------------------------------------------------------
// frequency_band_and_mode_lookup
// Loadable band/region interval table with first-match and nearest-edge search.
// ----------------------------------------------------------------------------
module frequency_band_and_mode_lookup #(
  parameter int MAX_BANDS            = fbml_pkg::MAX_BANDS_DEF,
  parameter int MAX_REGIONS_PER_BAND = fbml_pkg::MAX_REGIONS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // configuration
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [fbml_pkg::CFG_W-1:0]    cfg_bands_in_use,
  // requests
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [fbml_pkg::CMD_W-1:0]    in_cmd,
  input  wire logic [fbml_pkg::BSLOT_W-1:0]  in_band_slot,
  input  wire logic [fbml_pkg::RSLOT_W-1:0]  in_region_slot,
  input  wire logic [fbml_pkg::FREQ_W-1:0]   in_range_start,
  input  wire logic [fbml_pkg::FREQ_W-1:0]   in_range_end,
  input  wire logic [fbml_pkg::CNT_W-1:0]    in_regions_in_band,
  input  wire logic [fbml_pkg::MODE_W-1:0]   in_region_mode_code,
  input  wire logic [fbml_pkg::FREQ_W-1:0]   in_query_freq,
  input  wire logic                          in_allow_nearest,
  input  wire logic [fbml_pkg::MODE_W-1:0]   in_default_mode,
  // results
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [fbml_pkg::BSLOT_W-1:0]  out_band_index,
  output logic                               out_band_valid,
  output logic                               out_exact_hit,
  output logic      [fbml_pkg::MODE_W-1:0]   out_mode_out,
  output logic                               out_mode_from_table
);

  import fbml_pkg::*;

  localparam int REGION_DEPTH = MAX_BANDS * MAX_REGIONS_PER_BAND;
  localparam int BAW = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
  localparam int RAW = (REGION_DEPTH > 1) ? $clog2(REGION_DEPTH) : 1;
  localparam int BCW = $clog2(MAX_BANDS + 1);
  localparam int RCW = $clog2(MAX_REGIONS_PER_BAND + 1);
  localparam int BDW = 2 * FREQ_W + CNT_W;
  localparam int RDW = 2 * FREQ_W + MODE_W;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   bands_in_use_r;
  logic               out_valid_r, out_valid_nxt;

  logic [BCW-1:0]     b_r, b_nxt;
  logic [RCW-1:0]     r_r, r_nxt;
  logic [RCW-1:0]     rc_r, rc_nxt;
  logic [FREQ_W-1:0]  f_r, f_nxt;
  logic               nearest_r, nearest_nxt;
  logic [MODE_W-1:0]  dmode_r, dmode_nxt;
  logic               exact_r, exact_nxt;
  logic [BAW-1:0]     exact_idx_r, exact_idx_nxt;
  logic [FREQ_W-1:0]  best_r, best_nxt;
  logic [BAW-1:0]     near_idx_r, near_idx_nxt;
  logic               holds_r, holds_nxt;
  logic [FREQ_W-1:0]  dlow_r, dlow_nxt;
  logic [FREQ_W-1:0]  dhigh_r, dhigh_nxt;
  logic               mode_found_r, mode_found_nxt;
  logic [MODE_W-1:0]  mode_r, mode_nxt;

  logic [BSLOT_W-1:0] o_idx_r, o_idx_nxt;
  logic               o_bvalid_r, o_bvalid_nxt;
  logic               o_exact_r, o_exact_nxt;
  logic [MODE_W-1:0]  o_mode_r, o_mode_nxt;
  logic               o_from_tbl_r, o_from_tbl_nxt;

  // ---------------------------------------------------------------------------
  // Table memories
  // ---------------------------------------------------------------------------
  logic           in_acc;
  logic           band_wr_en, region_wr_en, band_rd_en, region_rd_en;
  logic [BAW-1:0] band_wr_addr;
  logic [RAW-1:0] region_wr_addr, region_rd_addr;
  logic [BDW-1:0] band_rd_data;
  logic [RDW-1:0] region_rd_data;

  assign in_acc = in_valid && in_ready;

  assign band_wr_en   = in_acc && (in_cmd == CMD_BAND_WR) &&
                        ({3'b0, in_band_slot} < 9'(MAX_BANDS));
  assign region_wr_en = in_acc && (in_cmd == CMD_REGION_WR) &&
                        ({3'b0, in_band_slot} < 9'(MAX_BANDS)) &&
                        ({3'b0, in_region_slot} < 7'(MAX_REGIONS_PER_BAND));
  assign band_wr_addr   = BAW'(in_band_slot);
  assign region_wr_addr = RAW'(32'(in_band_slot) * 32'(MAX_REGIONS_PER_BAND)
                               + 32'(in_region_slot));
  assign region_rd_addr = RAW'(32'(b_r) * 32'(MAX_REGIONS_PER_BAND) + 32'(r_r));
  assign band_rd_en     = (state_r == ST_BRD);
  assign region_rd_en   = (state_r == ST_RRD);

  fbml_ram #(
    .WIDTH (BDW),
    .DEPTH (MAX_BANDS)
  ) u_band_ram (
    .clk     (clk),
    .wr_en   (band_wr_en),
    .wr_addr (band_wr_addr),
    .wr_data ({in_range_start, in_range_end, in_regions_in_band}),
    .rd_en   (band_rd_en),
    .rd_addr (b_r[BAW-1:0]),
    .rd_data (band_rd_data)
  );

  fbml_ram #(
    .WIDTH (RDW),
    .DEPTH (REGION_DEPTH)
  ) u_region_ram (
    .clk     (clk),
    .wr_en   (region_wr_en),
    .wr_addr (region_wr_addr),
    .wr_data ({in_range_start, in_range_end, in_region_mode_code}),
    .rd_en   (region_rd_en),
    .rd_addr (region_rd_addr),
    .rd_data (region_rd_data)
  );

  logic [FREQ_W-1:0] bnd_low, bnd_high, reg_low, reg_high;
  logic [CNT_W-1:0]  bnd_total;
  logic [MODE_W-1:0] reg_mode;

  assign {bnd_low, bnd_high, bnd_total} = band_rd_data;
  assign {reg_low, reg_high, reg_mode}  = region_rd_data;

  // ---------------------------------------------------------------------------
  // Search control
  // ---------------------------------------------------------------------------
  logic [BCW-1:0]    n_bands;
  logic [BCW-1:0]    b_inc;
  logic [RCW-1:0]    r_inc;
  logic [RCW-1:0]    rc_cap;
  logic [FREQ_W-1:0] best1;
  logic [BAW-1:0]    idx1;
  logic              out_free;
  logic              fin_valid;

  assign n_bands = BCW'((9'(bands_in_use_r) > 9'(MAX_BANDS)) ? 9'(MAX_BANDS)
                                                           : 9'(bands_in_use_r));
  assign b_inc   = BCW'(b_r + 1'b1);
  assign r_inc   = RCW'(r_r + 1'b1);
  assign rc_cap  = RCW'((8'(bnd_total) > 8'(MAX_REGIONS_PER_BAND))
                        ? 8'(MAX_REGIONS_PER_BAND) : 8'(bnd_total));
  assign out_free  = !out_valid_r || out_ready;
  assign fin_valid = exact_r || nearest_r;

  // low edge first, then high edge; only a strictly smaller distance wins
  always_comb begin
    best1 = best_r;
    idx1  = near_idx_r;
    if (dlow_r < best_r) begin
      best1 = dlow_r;
      idx1  = b_r[BAW-1:0];
    end
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    b_nxt          = b_r;
    r_nxt          = r_r;
    rc_nxt         = rc_r;
    f_nxt          = f_r;
    nearest_nxt    = nearest_r;
    dmode_nxt      = dmode_r;
    exact_nxt      = exact_r;
    exact_idx_nxt  = exact_idx_r;
    best_nxt       = best_r;
    near_idx_nxt   = near_idx_r;
    holds_nxt      = holds_r;
    dlow_nxt       = dlow_r;
    dhigh_nxt      = dhigh_r;
    mode_found_nxt = mode_found_r;
    mode_nxt       = mode_r;
    o_idx_nxt      = o_idx_r;
    o_bvalid_nxt   = o_bvalid_r;
    o_exact_nxt    = o_exact_r;
    o_mode_nxt     = o_mode_r;
    o_from_tbl_nxt = o_from_tbl_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_cmd == CMD_LOOKUP)) begin
          b_nxt          = '0;
          f_nxt          = in_query_freq;
          nearest_nxt    = in_allow_nearest;
          dmode_nxt      = in_default_mode;
          exact_nxt      = 1'b0;
          exact_idx_nxt  = '0;
          best_nxt       = NEAR_LIMIT;
          near_idx_nxt   = '0;
          mode_found_nxt = 1'b0;
          mode_nxt       = in_default_mode;
          state_nxt      = (n_bands == '0) ? ST_DONE : ST_BRD;
          // an empty table gives no band even with nearest allowed
          if (n_bands == '0) begin
            nearest_nxt = 1'b0;
          end
        end
      end

      ST_BRD: begin
        state_nxt = ST_BEVAL;
      end

      ST_BEVAL: begin
        holds_nxt = (bnd_low <= f_r) && (f_r <= bnd_high);
        dlow_nxt  = (bnd_low >= f_r) ? (bnd_low - f_r) : (f_r - bnd_low);
        dhigh_nxt = (bnd_high >= f_r) ? (bnd_high - f_r) : (f_r - bnd_high);
        state_nxt = ST_BCMP;
      end

      ST_BCMP: begin
        best_nxt     = best1;
        near_idx_nxt = idx1;
        if (dhigh_r < best1) begin
          best_nxt     = dhigh_r;
          near_idx_nxt = b_r[BAW-1:0];
        end
        if (holds_r && !exact_r) begin
          exact_nxt     = 1'b1;
          exact_idx_nxt = b_r[BAW-1:0];
        end
        rc_nxt = rc_cap;
        r_nxt  = '0;
        if (holds_r && (rc_cap != '0)) begin
          state_nxt = ST_RRD;
        end else if (b_inc == n_bands) begin
          state_nxt = ST_DONE;
        end else begin
          b_nxt     = b_inc;
          state_nxt = ST_BRD;
        end
      end

      ST_RRD: begin
        state_nxt = ST_RCHK;
      end

      ST_RCHK: begin
        if ((reg_low <= f_r) && (f_r < reg_high)) begin
          // first matching region settles the mode; the band is already exact
          mode_found_nxt = 1'b1;
          mode_nxt       = reg_mode;
          state_nxt      = ST_DONE;
        end else if (r_inc != rc_r) begin
          r_nxt     = r_inc;
          state_nxt = ST_RRD;
        end else if (b_inc == n_bands) begin
          state_nxt = ST_DONE;
        end else begin
          b_nxt     = b_inc;
          state_nxt = ST_BRD;
        end
      end

      ST_DONE: begin
        // hold the result until the output register frees up
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          o_bvalid_nxt   = fin_valid;
          o_exact_nxt    = exact_r;
          o_idx_nxt      = !fin_valid ? '0 :
                           exact_r ? BSLOT_W'(exact_idx_r) : BSLOT_W'(near_idx_r);
          o_mode_nxt     = mode_r;
          o_from_tbl_nxt = mode_found_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      out_valid_r    <= 1'b0;
      bands_in_use_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        bands_in_use_r <= cfg_bands_in_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    b_r          <= b_nxt;
    r_r          <= r_nxt;
    rc_r         <= rc_nxt;
    f_r          <= f_nxt;
    nearest_r    <= nearest_nxt;
    dmode_r      <= dmode_nxt;
    exact_r      <= exact_nxt;
    exact_idx_r  <= exact_idx_nxt;
    best_r       <= best_nxt;
    near_idx_r   <= near_idx_nxt;
    holds_r      <= holds_nxt;
    dlow_r       <= dlow_nxt;
    dhigh_r      <= dhigh_nxt;
    mode_found_r <= mode_found_nxt;
    mode_r       <= mode_nxt;
    o_idx_r      <= o_idx_nxt;
    o_bvalid_r   <= o_bvalid_nxt;
    o_exact_r    <= o_exact_nxt;
    o_mode_r     <= o_mode_nxt;
    o_from_tbl_r <= o_from_tbl_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_band_index      = o_idx_r;
  assign out_band_valid      = o_bvalid_r;
  assign out_exact_hit       = o_exact_r;
  assign out_mode_out        = o_mode_r;
  assign out_mode_from_table = o_from_tbl_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_table_mode_needs_hit : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_from_tbl_r |-> o_exact_r)
    else $error("region mode reported without a containing band");

  a_exact_is_valid : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && o_exact_r |-> o_bvalid_r)
    else $error("exact hit reported on an invalid band");

  a_invalid_index_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !o_bvalid_r |-> (o_idx_r == '0))
    else $error("nonzero band index with no band");

  a_scan_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_BRD |-> b_r < n_bands)
    else $error("band scan ran past bands in use");

  a_region_check_order : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RCHK |-> $past(state_r) == ST_RRD)
    else $error("region check without a preceding region read");

endmodule : frequency_band_and_mode_lookup
`default_nettype wire

// ===== tb/sv/tb_frequency_band_and_mode_lookup.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frequency_band_and_mode_lookup
// Loads the band and region tables, steps the band count register through
// its range and checks every lookup result against a behavioral predictor,
// with random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module tb_frequency_band_and_mode_lookup;
  import fbml_pkg::*;

  localparam int NBANDS       = MAX_BANDS_DEF;
  localparam int NREGIONS     = MAX_REGIONS_DEF;
  localparam int REGION_DEPTH = NBANDS * NREGIONS;
  localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
  localparam logic [FREQ_W-1:0] FREQ_MAX   = '1;
  localparam int CYCLE_LIMIT   = 12_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 3000;
  localparam int PHASE_ITEMS   = 40;
  localparam int NPHASES       = 9;
  localparam int BAND_COUNT_PLAN [NPHASES] = '{64, 1, 127, 33, 65, 64, 2, 100, 64};

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [BSLOT_W-1:0] band_slot;
    logic [RSLOT_W-1:0] region_slot;
    logic [FREQ_W-1:0]  range_start;
    logic [FREQ_W-1:0]  range_end;
    logic [CNT_W-1:0]   regions_in_band;
    logic [MODE_W-1:0]  region_mode_code;
    logic [FREQ_W-1:0]  query_freq;
    logic               allow_nearest;
    logic [MODE_W-1:0]  default_mode;
  } band_req_t;

  typedef struct packed {
    logic [BSLOT_W-1:0] band_index;
    logic               band_valid;
    logic               exact_hit;
    logic [MODE_W-1:0]  mode;
    logic               mode_from_table;
  } band_match_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic             cfg_valid        = 1'b0;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_bands_in_use = '0;

  logic      in_valid = 1'b0;
  logic      in_ready;
  band_req_t req_now  = '0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [BSLOT_W-1:0] out_band_index;
  logic               out_band_valid;
  logic               out_exact_hit;
  logic [MODE_W-1:0]  out_mode_out;
  logic               out_mode_from_table;

  int send_idle_pct  = 31;
  int recv_stall_pct = 69;

  // table image as the block holds it, updated on accepted requests
  logic [FREQ_W-1:0] band_lo_m [NBANDS];
  logic [FREQ_W-1:0] band_hi_m [NBANDS];
  logic [CNT_W-1:0]  band_cnt_m [NBANDS];
  logic [FREQ_W-1:0] reg_lo_m [REGION_DEPTH];
  logic [FREQ_W-1:0] reg_hi_m [REGION_DEPTH];
  logic [MODE_W-1:0] reg_mode_m [REGION_DEPTH];
  logic [CFG_W-1:0]  bands_active_m = '0;

  // table image as queued, used to aim lookups
  logic [FREQ_W-1:0] plan_lo [NBANDS];
  logic [FREQ_W-1:0] plan_hi [NBANDS];
  int                plan_cnt [NBANDS];
  logic [FREQ_W-1:0] plan_rlo [REGION_DEPTH];
  logic [FREQ_W-1:0] plan_rhi [REGION_DEPTH];
  bit                region_loaded [REGION_DEPTH];

  band_req_t   pending_reqs [$];
  band_match_t expected_matches [$];
  band_match_t exp_match;

  bit req_taken       = 1'b0;
  int mismatches      = 0;
  int lookups_checked = 0;
  int table_writes    = 0;
  int cfg_writes      = 0;
  int cycle_count     = 0;

  frequency_band_and_mode_lookup u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_bands_in_use    (cfg_bands_in_use),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_cmd              (req_now.cmd),
    .in_band_slot        (req_now.band_slot),
    .in_region_slot      (req_now.region_slot),
    .in_range_start      (req_now.range_start),
    .in_range_end        (req_now.range_end),
    .in_regions_in_band  (req_now.regions_in_band),
    .in_region_mode_code (req_now.region_mode_code),
    .in_query_freq       (req_now.query_freq),
    .in_allow_nearest    (req_now.allow_nearest),
    .in_default_mode     (req_now.default_mode),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_band_index      (out_band_index),
    .out_band_valid      (out_band_valid),
    .out_exact_hit       (out_exact_hit),
    .out_mode_out        (out_mode_out),
    .out_mode_from_table (out_mode_from_table)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [FREQ_W-1:0] freq_gap(input logic [FREQ_W-1:0] a,
                                                 input logic [FREQ_W-1:0] f);
    return (a >= f) ? a - f : f - a;
  endfunction

  function automatic band_match_t classify_freq(input band_req_t r);
    band_match_t       m;
    int unsigned       nb;
    int unsigned       rc;
    int unsigned       k;
    logic [FREQ_W-1:0] f;
    logic [FREQ_W-1:0] best;
    logic [FREQ_W-1:0] gap;
    bit                held;
    m  = '0;
    f  = r.query_freq;
    nb = (bands_active_m > NBANDS) ? NBANDS : bands_active_m;
    for (int b = 0; b < nb && !m.exact_hit; b++) begin
      if (band_lo_m[b] <= f && f <= band_hi_m[b]) begin
        m.band_index = BSLOT_W'(b);
        m.band_valid = 1'b1;
        m.exact_hit  = 1'b1;
      end
    end
    // nearest edge; a tie keeps the earlier pick
    if (!m.exact_hit && r.allow_nearest && nb > 0) begin
      best         = NEAR_LIMIT;
      m.band_index = '0;
      m.band_valid = 1'b1;
      for (int b = 0; b < nb; b++) begin
        gap = freq_gap(band_lo_m[b], f);
        if (gap < best) begin
          best         = gap;
          m.band_index = BSLOT_W'(b);
        end
        gap = freq_gap(band_hi_m[b], f);
        if (gap < best) begin
          best         = gap;
          m.band_index = BSLOT_W'(b);
        end
      end
    end
    m.mode = r.default_mode;
    for (int b = 0; b < nb && !m.mode_from_table; b++) begin
      held = band_lo_m[b] <= f && f <= band_hi_m[b];
      rc   = (band_cnt_m[b] > NREGIONS) ? NREGIONS : band_cnt_m[b];
      for (int q = 0; held && q < rc && !m.mode_from_table; q++) begin
        k = b * NREGIONS + q;
        if (reg_lo_m[k] <= f && f < reg_hi_m[k]) begin
          m.mode            = reg_mode_m[k];
          m.mode_from_table = 1'b1;
        end
      end
    end
    return m;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      req_taken = 1'b1;
      if (req_now.cmd == CMD_BAND_WR) begin
        band_lo_m[req_now.band_slot]  = req_now.range_start;
        band_hi_m[req_now.band_slot]  = req_now.range_end;
        band_cnt_m[req_now.band_slot] = req_now.regions_in_band;
        table_writes++;
      end else if (req_now.cmd == CMD_REGION_WR) begin
        reg_lo_m[{req_now.band_slot, req_now.region_slot}]   = req_now.range_start;
        reg_hi_m[{req_now.band_slot, req_now.region_slot}]   = req_now.range_end;
        reg_mode_m[{req_now.band_slot, req_now.region_slot}] = req_now.region_mode_code;
        table_writes++;
      end else if (req_now.cmd == CMD_LOOKUP) begin
        expected_matches.push_back(classify_freq(req_now));
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || req_taken)) begin
      req_taken = 1'b0;
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        req_now  <= pending_reqs.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result monitor
  always @(negedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_matches.size() == 0) begin
        flag_mismatch("result with no lookup outstanding");
      end else begin
        exp_match = expected_matches.pop_front();
        lookups_checked++;
        if (out_band_index !== exp_match.band_index)
          flag_mismatch($sformatf("lookup %0d band_index %0d, expected %0d",
                                  lookups_checked, out_band_index, exp_match.band_index));
        if (out_band_valid !== exp_match.band_valid)
          flag_mismatch($sformatf("lookup %0d band_valid %0b, expected %0b",
                                  lookups_checked, out_band_valid, exp_match.band_valid));
        if (out_exact_hit !== exp_match.exact_hit)
          flag_mismatch($sformatf("lookup %0d exact_hit %0b, expected %0b",
                                  lookups_checked, out_exact_hit, exp_match.exact_hit));
        if (out_mode_out !== exp_match.mode)
          flag_mismatch($sformatf("lookup %0d mode_out %0d, expected %0d",
                                  lookups_checked, out_mode_out, exp_match.mode));
        if (out_mode_from_table !== exp_match.mode_from_table)
          flag_mismatch($sformatf("lookup %0d mode_from_table %0b, expected %0b",
                                  lookups_checked, out_mode_from_table,
                                  exp_match.mode_from_table));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic band_req_t noise_req();
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    return bits[$bits(band_req_t)-1:0];
  endfunction

  task automatic queue_region(input int bs, input int rs);
    band_req_t   r;
    logic [31:0] span;
    logic [31:0] lo;
    logic [31:0] hi;
    int          k;
    k    = bs * NREGIONS + rs;
    span = (plan_lo[bs] <= plan_hi[bs]) ? plan_hi[bs] - plan_lo[bs] : 32'd1000;
    lo   = plan_lo[bs] + $urandom_range(span);
    if (lo > FREQ_MAX) lo = FREQ_MAX;
    hi = lo + 1 + $urandom_range(span / 3);
    case ($urandom_range(9))
      0: hi = lo;                 // empty region
      1: begin                    // reversed region
        hi = lo;
        lo = lo + 1 + $urandom_range(5000);
      end
      default: ;
    endcase
    if (lo > FREQ_MAX) lo = FREQ_MAX;
    if (hi > FREQ_MAX) hi = FREQ_MAX;
    r               = noise_req();
    r.cmd           = CMD_REGION_WR;
    r.band_slot     = BSLOT_W'(bs);
    r.region_slot   = RSLOT_W'(rs);
    r.range_start   = lo[FREQ_W-1:0];
    r.range_end     = hi[FREQ_W-1:0];
    plan_rlo[k]      = lo[FREQ_W-1:0];
    plan_rhi[k]      = hi[FREQ_W-1:0];
    region_loaded[k] = 1'b1;
    pending_reqs.push_back(r);
  endtask

  task automatic queue_band(input int bs, input logic [FREQ_W-1:0] lo,
                            input logic [FREQ_W-1:0] hi, input int cnt);
    band_req_t r;
    plan_lo[bs]  = lo;
    plan_hi[bs]  = hi;
    plan_cnt[bs] = cnt;
    // fill every region the count reaches before the count is stored
    for (int q = 0; q < cnt && q < NREGIONS; q++)
      if (!region_loaded[bs * NREGIONS + q]) queue_region(bs, q);
    r                 = noise_req();
    r.cmd             = CMD_BAND_WR;
    r.band_slot       = BSLOT_W'(bs);
    r.range_start     = lo;
    r.range_end       = hi;
    r.regions_in_band = CNT_W'(cnt);
    pending_reqs.push_back(r);
  endtask

  task automatic queue_lookup(input logic [FREQ_W-1:0] f, input bit near,
                              input logic [MODE_W-1:0] dm);
    band_req_t r;
    r               = noise_req();
    r.cmd           = CMD_LOOKUP;
    r.query_freq    = f;
    r.allow_nearest = near;
    r.default_mode  = dm;
    pending_reqs.push_back(r);
  endtask

  function automatic logic [FREQ_W-1:0] pick_freq(input int span_bands);
    int          b;
    int          b2;
    int          q;
    int          k;
    int          pick;
    logic [31:0] e;
    logic [31:0] w;
    b    = $urandom_range(span_bands - 1);
    pick = $urandom_range(99);
    if (pick < 35 && plan_lo[b] <= plan_hi[b]) begin
      w = plan_lo[b] + $urandom_range(plan_hi[b] - plan_lo[b]);
    end else if (pick < 55) begin
      e = $urandom_range(1) ? plan_lo[b] : plan_hi[b];
      q = $urandom_range(3);
      w = $urandom_range(1) ? e + q : ((e >= q) ? e - q : 32'd0);
    end else if (pick < 65) begin
      b2 = $urandom_range(span_bands - 1);
      w  = (32'(plan_hi[b]) + plan_lo[b2]) >> 1;
    end else if (pick < 80 && plan_cnt[b] != 0) begin
      q = $urandom_range(((plan_cnt[b] > NREGIONS) ? NREGIONS : plan_cnt[b]) - 1);
      k = b * NREGIONS + q;
      w = (plan_rlo[k] <= plan_rhi[k]) ?
          plan_rlo[k] + $urandom_range(plan_rhi[k] - plan_rlo[k]) : plan_rlo[k];
    end else begin
      w = $urandom & FREQ_MAX;
    end
    if (w > FREQ_MAX) w = FREQ_MAX;
    return w[FREQ_W-1:0];
  endfunction

  task automatic load_table();
    logic [31:0] lo;
    logic [31:0] hi;
    for (int b = 0; b < NBANDS; b++) begin
      lo = b * 32_000_000 + $urandom_range(4_000_000);
      hi = lo + 1000 + $urandom_range(24_000_000);
      case (b)
        0:  lo = 0;
        9:  begin                       // overlap band 8
          lo = plan_lo[8] + 1000;
          hi = plan_hi[8] + 3_000_000;
        end
        20: begin                       // reversed band
          hi = lo;
          lo = lo + 5_000_000;
        end
        30: lo = plan_lo[28];           // covers bands 28 and 29
        41: lo[0] = plan_hi[40][0];     // even gap, so the midpoint ties
        63: hi = FREQ_MAX;
        default: ;
      endcase
      queue_band(b, lo[FREQ_W-1:0], hi[FREQ_W-1:0],
                 (b == 5) ? 16 : (b == 6) ? 31 : (b == 7) ? 17 : $urandom_range(3));
    end
  endtask

  task automatic queue_random_phase(input int quota, input int span_bands);
    int          done;
    int          pick;
    int          bs;
    band_req_t   r;
    logic [31:0] lo;
    logic [31:0] hi;
    done = 0;
    while (done < quota) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        r     = noise_req();
        r.cmd = CMD_UNUSED;
        pending_reqs.push_back(r);
      end else begin
        done++;
        if (pick < 11) begin
          bs = $urandom_range(NBANDS - 1);
          if ($urandom_range(3) == 0) begin
            lo = $urandom & FREQ_MAX;
            hi = $urandom & FREQ_MAX;
          end else begin
            lo = plan_lo[bs] + $urandom_range(2_000_000);
            hi = plan_hi[bs] + $urandom_range(2_000_000);
          end
          if (lo > FREQ_MAX) lo = FREQ_MAX;
          if (hi > FREQ_MAX) hi = FREQ_MAX;
          queue_band(bs, lo[FREQ_W-1:0], hi[FREQ_W-1:0],
                     ($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(4));
        end else if (pick < 21) begin
          queue_region($urandom_range(NBANDS - 1), $urandom_range(NREGIONS - 1));
        end else begin
          queue_lookup(pick_freq(span_bands), $urandom_range(1), $urandom_range(15));
        end
      end
    end
  endtask

  task automatic drain_and_settle(input int extra);
    while (pending_reqs.size() != 0 || in_valid || expected_matches.size() != 0)
      @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_band_count(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg_valid        <= 1'b1;
    cfg_bands_in_use <= v;
    do @(posedge clk); while (!cfg_ready);
    bands_active_m = v;
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    logic [FREQ_W-1:0] mid;
    int                nb;
    band_req_t         spare;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // empty table: nothing is searched
    write_band_count('0);
    queue_lookup('0, 1'b0, 4'hF);
    queue_lookup(FREQ_MAX, 1'b1, 4'h0);
    spare     = noise_req();
    spare.cmd = CMD_UNUSED;
    pending_reqs.push_back(spare);
    load_table();
    drain_and_settle(SETTLE_CYCLES);

    write_band_count(7'd64);
    queue_lookup('0, 1'b0, 4'hF);
    queue_lookup(FREQ_MAX, 1'b1, 4'h0);
    queue_lookup(plan_hi[8], 1'b0, 4'h5);
    queue_lookup(plan_hi[20], 1'b1, 4'h3);
    queue_lookup(plan_hi[20], 1'b0, 4'h3);
    mid = plan_hi[40] + (plan_lo[41] - plan_hi[40]) / 2;
    queue_lookup(mid, 1'b1, 4'hA);
    queue_lookup(mid, 1'b0, 4'hA);
    queue_lookup(plan_rlo[5 * NREGIONS], 1'b1, 4'h6);
    queue_lookup(plan_rhi[5 * NREGIONS], 1'b1, 4'h6);
    queue_lookup(plan_lo[6] + (plan_hi[6] - plan_lo[6]) / 2, 1'b0, 4'h9);
    queue_lookup(plan_lo[7] + (plan_hi[7] - plan_lo[7]) / 2, 1'b0, 4'h9);
    queue_lookup(plan_lo[29] + (plan_hi[29] - plan_lo[29]) / 2, 1'b1, 4'hC);
    drain_and_settle(SETTLE_CYCLES);

    // far from every edge: band 0 comes back as the nearest; just inside the limit, band 2 does
    write_band_count(7'd3);
    queue_lookup(FREQ_MAX, 1'b1, 4'h1);
    queue_lookup(plan_hi[2] + NEAR_LIMIT, 1'b1, 4'h2);
    queue_lookup(plan_hi[2] + NEAR_LIMIT - 1, 1'b1, 4'h4);

    for (int p = 0; p < NPHASES; p++) begin
      if (p == 3) begin
        send_idle_pct  = 69;
        recv_stall_pct = 31;
      end else if (p == 6) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      drain_and_settle(SETTLE_CYCLES);
      write_band_count(CFG_W'(BAND_COUNT_PLAN[p]));
      nb = (BAND_COUNT_PLAN[p] > NBANDS) ? NBANDS : BAND_COUNT_PLAN[p];
      queue_random_phase(PHASE_ITEMS, nb);
    end
    drain_and_settle(TAIL_CYCLES);

    $display("summary: %0d lookups compared, %0d table entries written", lookups_checked,
             table_writes);
    $display("summary: %0d band count settings from 0 to 127, %0d mismatches", cfg_writes,
             mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
